// File: hw/rtl/tbs_pkg.sv
// ----------------------------------------------------------------------------
// tbs_pkg
// Shared widths, register indexes and reset values for the token batch
// splitter.
// ----------------------------------------------------------------------------
package tbs_pkg;

  localparam int TOKEN_W        = 8;
  localparam int LIMIT_W        = 6;
  localparam int MASK_W         = 16;
  localparam int CFG_DATA_W     = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int MAX_BATCH_DEF  = 32;

  localparam logic [CFG_IDX_W-1:0] REG_BATCH_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PUNCT_MASK  = 2'd1;

  localparam logic [LIMIT_W-1:0] RESET_BATCH_LIMIT = 6'd32;
  localparam logic [MASK_W-1:0]  RESET_PUNCT_MASK  = 16'd1662;

  // Ids below 16 with their mask bit set are phrase breaks.
  function automatic logic is_break(input logic [TOKEN_W-1:0] tok,
                                    input logic [MASK_W-1:0]  mask);
    logic hit;
    hit = (tok[TOKEN_W-1:4] == '0) && mask[tok[3:0]];
    return hit;
  endfunction

endpackage

// File: hw/rtl/tbs_ring.sv
// ----------------------------------------------------------------------------
// tbs_ring
// Token ring storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tbs_ring import tbs_pkg::*; #(
  parameter int DEPTH = MAX_BATCH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [TOKEN_W-1:0] wdata,
  input  logic               re,
  input  logic [AW-1:0]      raddr,
  output logic [TOKEN_W-1:0] rdata
);

  logic [TOKEN_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds between read strobes
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/token_batch_splitter.sv
// ----------------------------------------------------------------------------
// token_batch_splitter
// Buffers a token sequence and re-emits it in batches cut at phrase breaks.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one token request (tdata = token, tlast = last
//   token of the sequence). Master stream re-emits tokens in order with
//   tlast = end of batch and tuser = end of sequence.
//   The config port (cfg_we/cfg_index/cfg_data) sets batch_limit (index 0)
//   and punct_mask (index 1); write only while the block is idle.
// Sequencing:
//   One token at a time; s_tready is high only in idle. A token that causes
//   no output passes through accept, limit check and store. A cut adds a
//   backward scan for the last break, one probe at a time (ring read, then
//   test), up to the clamped limit in probes, and every emitted token takes
//   a ring read, then a load of the output register. The single ring read
//   port and the shared slot adder set these steps.
// Reset:
//   rst (sync, high) empties the ring, sets head to 0, batch_limit to 32 and
//   punct_mask to 1662. No clearing pass: slots are read only once written.
// Stall:
//   A stalled master holds the output register; the sequencer waits in the
//   load step. The last result of a request may still wait in the output
//   register while the next request is accepted.
// ----------------------------------------------------------------------------
module token_batch_splitter import tbs_pkg::*; #(
  parameter int MAX_BATCH = MAX_BATCH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // config write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // slave stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [TOKEN_W-1:0]    s_tdata,   // [7:0] token
  input  logic                  s_tlast,   // seq_last
  // master stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [TOKEN_W-1:0]    m_tdata,   // [7:0] out_token
  output logic                  m_tlast,   // batch_end
  output logic                  m_tuser    // [0] seq_end
);

  localparam int PW = $clog2(MAX_BATCH);      // ring slot index
  localparam int CW = $clog2(MAX_BATCH + 1);  // counts 0..MAX_BATCH

  // sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_SRD   = 3'd2;  // scan: read probe
  localparam logic [2:0] S_STST  = 3'd3;  // scan: test probe
  localparam logic [2:0] S_ERD   = 3'd4;  // emit: read token
  localparam logic [2:0] S_ELD   = 3'd5;  // emit: load output reg
  localparam logic [2:0] S_STORE = 3'd6;

  logic [2:0]         state;
  logic [LIMIT_W-1:0] batch_limit;
  logic [MASK_W-1:0]  punct_mask;
  logic [PW-1:0]      head;
  logic [CW-1:0]      fill;
  logic [CW-1:0]      lim;
  logic [CW-1:0]      pos;    // scan offset
  logic [CW-1:0]      cut;    // tokens in current batch
  logic [CW-1:0]      idx;    // emit offset
  logic               flush;
  logic [TOKEN_W-1:0] tok;
  logic               last;

  logic               out_valid;
  logic [TOKEN_W-1:0] out_token;
  logic               out_bend;
  logic               out_send;

  // ---------------------------------------------------------------------------
  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      batch_limit <= RESET_BATCH_LIMIT;
      punct_mask  <= RESET_PUNCT_MASK;
    end else if (cfg_we) begin
      if (cfg_index == REG_BATCH_LIMIT) begin
        batch_limit <= cfg_data[LIMIT_W-1:0];
      end else if (cfg_index == REG_PUNCT_MASK) begin
        punct_mask <= cfg_data[MASK_W-1:0];
      end
    end
  end

  // clamp limit into 1..MAX_BATCH
  logic [CW-1:0] lim_clamped;
  always_comb begin
    if (batch_limit == '0) begin
      lim_clamped = CW'(1);
    end else if ({1'b0, batch_limit} > (LIMIT_W+1)'(MAX_BATCH)) begin
      lim_clamped = CW'(MAX_BATCH);
    end else begin
      lim_clamped = batch_limit[CW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // shared slot adder: (head + offset) mod MAX_BATCH, sum stays below 2*MAX
  logic [CW-1:0] slot_off;
  logic [CW:0]   slot_sum;
  logic [CW:0]   slot_wrap;
  logic [PW-1:0] slot;

  always_comb begin
    unique case (state)
      S_SRD:   slot_off = pos;
      S_ERD:   slot_off = idx;
      S_STORE: slot_off = fill;
      default: slot_off = cut;
    endcase
    slot_sum  = (CW+1)'(head) + (CW+1)'(slot_off);
    slot_wrap = (slot_sum >= (CW+1)'(MAX_BATCH)) ? slot_sum - (CW+1)'(MAX_BATCH)
                                                 : slot_sum;
    slot      = slot_wrap[PW-1:0];
  end

  // ---------------------------------------------------------------------------
  // token ring
  logic               ring_we;
  logic               ring_re;
  logic [TOKEN_W-1:0] ring_rdata;

  assign ring_we = (state == S_STORE);
  assign ring_re = (state == S_SRD) || (state == S_ERD);

  tbs_ring #(
    .DEPTH (MAX_BATCH),
    .AW    (PW)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (slot),
    .wdata (tok),
    .re    (ring_re),
    .raddr (slot),
    .rdata (ring_rdata)
  );

  // ---------------------------------------------------------------------------
  // sequencer
  logic out_load;
  logic idx_is_end;

  assign out_load   = (state == S_ELD) && (!out_valid || m_tready);
  assign idx_is_end = (({1'b0, idx} + (CW+1)'(1)) == {1'b0, cut});
  assign s_tready   = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      fill  <= '0;
      flush <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            tok   <= s_tdata;
            last  <= s_tlast;
            lim   <= lim_clamped;
            flush <= 1'b0;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (fill >= lim) begin
            pos   <= lim - CW'(1);
            state <= S_SRD;
          end else begin
            state <= S_STORE;
          end
        end
        S_SRD: begin
          state <= S_STST;
        end
        S_STST: begin
          if (is_break(ring_rdata, punct_mask)) begin
            cut   <= pos + CW'(1);
            idx   <= '0;
            state <= S_ERD;
          end else if (pos == '0) begin
            // no break in the window: cut at the limit
            cut   <= lim;
            idx   <= '0;
            state <= S_ERD;
          end else begin
            pos   <= pos - CW'(1);
            state <= S_SRD;
          end
        end
        S_ERD: begin
          state <= S_ELD;
        end
        S_ELD: begin
          if (out_load) begin
            if (!idx_is_end) begin
              idx   <= idx + CW'(1);
              state <= S_ERD;
            end else if (flush) begin
              head  <= '0;
              fill  <= '0;
              state <= S_IDLE;
            end else begin
              head  <= slot;
              fill  <= fill - cut;
              state <= S_CHECK;
            end
          end
        end
        S_STORE: begin
          fill <= fill + CW'(1);
          if (last) begin
            cut   <= fill + CW'(1);
            idx   <= '0;
            flush <= 1'b1;
            state <= S_ERD;
          end else begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_token <= ring_rdata;
      out_bend  <= idx_is_end;
      out_send  <= idx_is_end && flush;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_token;
  assign m_tlast  = out_bend;
  assign m_tuser  = out_send;

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for token_batch_splitter. Token requests go from a
// queue into the slave stream. Each accepted request runs through a batch
// predictor, and the results that it yields are queued in arrival order. The
// master stream is checked field by field against that queue. The run covers
// directed corner sequences, then random sequences under several limit and
// mask settings, with random stalls on both sides in two of three modes.
// One phase also holds off the output for a long stretch.
// ----------------------------------------------------------------------------
module testbench import tbs_pkg::*; ();

  localparam int RING_DEPTH     = MAX_BATCH_DEF;
  localparam int RING_AW        = $clog2(RING_DEPTH);
  localparam int SETTLE_CYCLES  = 10;
  localparam int TAIL_CYCLES    = 50;
  localparam int HOLD_OFF_LEN   = 300;
  localparam int WATCHDOG_LIMIT = 2000;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [TOKEN_W-1:0] tok;
    logic               seq_last;
  } token_req_t;

  typedef struct packed {
    logic [TOKEN_W-1:0] tok;
    logic               batch_end;
    logic               seq_end;
  } batch_tok_t;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_BATCH_LIMIT;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [TOKEN_W-1:0]    s_tdata   = '0;   // [7:0] token
  logic                  s_tlast   = 1'b0; // seq_last
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [TOKEN_W-1:0]    m_tdata;          // [7:0] out_token
  logic                  m_tlast;          // batch_end
  logic                  m_tuser;          // [0] seq_end

  token_batch_splitter dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Stimulus and expected output
  token_req_t token_q[$];      // requests not yet offered
  batch_tok_t batch_q[$];      // predicted output tokens, oldest first

  // Idle odds in percent; set per phase by the sequencer below
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  bit          hold_off_go  = 1'b0;

  // Run statistics
  int unsigned err_cnt     = 0;
  int unsigned tokens_in   = 0;
  int unsigned seqs_in     = 0;
  int unsigned tokens_out  = 0;
  int unsigned batches_out = 0;
  int unsigned reg_writes  = 0;
  int unsigned quiet_cycles = 0;

  // --------------------------------------------------------------------------
  // Batch predictor: its own ring, fill level and register copies
  // --------------------------------------------------------------------------
  logic [TOKEN_W-1:0] ring [RING_DEPTH];
  int unsigned        ring_head = 0;
  int unsigned        ring_fill = 0;
  logic [LIMIT_W-1:0] limit_reg = RESET_BATCH_LIMIT;
  logic [MASK_W-1:0]  mask_reg  = RESET_PUNCT_MASK;

  function automatic int unsigned eff_limit();
    int unsigned lim;
    lim = limit_reg;
    if (lim == 0) lim = 1;                 // zero behaves as one
    if (lim > RING_DEPTH) lim = RING_DEPTH; // clamp to ring depth
    return lim;
  endfunction

  function automatic bit phrase_break(input logic [TOKEN_W-1:0] tok);
    return (tok < 16) && mask_reg[tok[3:0]];
  endfunction

  // ring slot at an offset from the head
  function automatic logic [RING_AW-1:0] ring_slot(input int unsigned off);
    return RING_AW'((ring_head + off) % RING_DEPTH);
  endfunction

  function automatic void queue_result(input logic [TOKEN_W-1:0] tok,
                                       input logic be, input logic se);
    batch_tok_t r;
    r.tok       = tok;
    r.batch_end = be;
    r.seq_end   = se;
    batch_q.insert(batch_q.size(), r);
  endfunction

  task automatic predict_batches(input logic [TOKEN_W-1:0] tok, input logic seq_last);
    int unsigned lim;
    int unsigned cut;
    int unsigned k;
    bit          found;
    lim = eff_limit();
    // Full (or over-full after a lowered limit): cut after the last break in
    // the first lim tokens, else at lim. Repeats until below the limit.
    while (ring_fill >= lim) begin
      cut   = lim;
      found = 1'b0;
      for (k = lim; k > 0 && !found; k--) begin
        if (phrase_break(ring[ring_slot(k - 1)])) begin
          cut   = k;
          found = 1'b1;
        end
      end
      for (k = 0; k < cut; k++)
        queue_result(ring[ring_slot(k)], k + 1 == cut, 1'b0);
      ring_head = (ring_head + cut) % RING_DEPTH;
      ring_fill = ring_fill - cut;
    end
    ring[ring_slot(ring_fill)] = tok;
    ring_fill++;
    // Sequence end flushes everything as one final batch
    if (seq_last) begin
      for (k = 0; k < ring_fill; k++)
        queue_result(ring[ring_slot(k)], k + 1 == ring_fill, k + 1 == ring_fill);
      ring_head = 0;
      ring_fill = 0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Request driver: offers queued tokens, random gaps, predicts on accept
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    token_req_t req;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_batches(s_tdata, s_tlast);
        tokens_in++;
        if (s_tlast) seqs_in++;
      end
      if (!s_tvalid || s_tready) begin
        if (token_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          req = token_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= req.tok;
          s_tlast  <= req.seq_last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor: random back-pressure, one long hold-off, field checks
  // --------------------------------------------------------------------------
  int unsigned hold_left = 0;
  bit          hold_used = 1'b0;

  always @(posedge clk) begin
    batch_tok_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        tokens_out++;
        if (m_tlast) batches_out++;
        if (batch_q.size() == 0) begin
          $error("unexpected output token %0d (batch_end %0b seq_end %0b)",
                 m_tdata, m_tlast, m_tuser);
          err_cnt++;
        end else begin
          want = batch_q.pop_front();
          if (m_tdata !== want.tok) begin
            $error("out_token: expected %0d, got %0d", want.tok, m_tdata);
            err_cnt++;
          end
          if (m_tlast !== want.batch_end) begin
            $error("batch_end: expected %0b, got %0b", want.batch_end, m_tlast);
            err_cnt++;
          end
          if (m_tuser !== want.seq_end) begin
            $error("seq_end: expected %0b, got %0b", want.seq_end, m_tuser);
            err_cnt++;
          end
        end
      end
      // Long hold-off lets the ring fill and the input stall
      if (hold_off_go && !hold_used) begin
        hold_used <= 1'b1;
        hold_left <= HOLD_OFF_LEN;
        m_tready  <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_tready  <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long with no handshake and no register write
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("watchdog: %0d cycles without progress", WATCHDOG_LIMIT);
    $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sequencer helpers
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
    // other indexes are ignored by the block
    case (idx)
      REG_BATCH_LIMIT: limit_reg = val[LIMIT_W-1:0];
      REG_PUNCT_MASK:  mask_reg  = val;
      default: ;
    endcase
  endtask

  // Idle point: everything offered, accepted and emitted, then a settling wait
  // for a token still being stored
  task automatic wait_idle();
    while (token_q.size() != 0 || s_tvalid || batch_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_tok(input logic [TOKEN_W-1:0] tok, input logic seq_last);
    token_req_t req;
    req.tok      = tok;
    req.seq_last = seq_last;
    token_q.insert(token_q.size(), req);
  endtask

  // Low ids come up in nearly half the picks so that breaks show up often
  function automatic logic [TOKEN_W-1:0] pick_token();
    if ($urandom_range(99) < 45) return TOKEN_W'($urandom_range(15));
    return TOKEN_W'($urandom_range(255));
  endfunction

  // Random sequences totalling n tokens; the last one may stay open so the
  // ring carries tokens across the next register change
  task automatic random_segment(input int unsigned n, input bit leave_open);
    int unsigned left;
    int unsigned len;
    int unsigned k;
    left = n;
    while (left != 0) begin
      len = $urandom_range(2 * eff_limit() + 2, 1);
      if (len > left) len = left;
      left = left - len;
      for (k = 0; k < len; k++)
        push_tok(pick_token(), (k + 1 == len) && !(leave_open && left == 0));
    end
  endtask

  // Mostly small limits, sometimes zero, one, full depth or above it
  task automatic random_config();
    logic [LIMIT_W-1:0] lim;
    logic [MASK_W-1:0]  mask;
    case ($urandom_range(9))
      0:       lim = '0;
      1:       lim = LIMIT_W'(1);
      2:       lim = LIMIT_W'(RING_DEPTH);
      3:       lim = LIMIT_W'($urandom_range(63, RING_DEPTH + 1));
      default: lim = LIMIT_W'($urandom_range(8, 2));
    endcase
    case ($urandom_range(3))
      0:       mask = '0;
      1:       mask = '1;
      default: mask = MASK_W'($urandom_range(65535));
    endcase
    // upper data bits are don't-care for the limit register
    write_reg(REG_BATCH_LIMIT, {CFG_DATA_W'($urandom_range(1023)) << LIMIT_W} | lim);
    write_reg(REG_PUNCT_MASK, mask);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned mode;
    int unsigned seg;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    src_idle_pct = 23;
    snk_idle_pct = 52;

    // Reset settings: plain flush, all-ones and all-zeros ids, lone token
    push_tok(8'hFF, 1'b0);
    push_tok(8'h00, 1'b0);
    push_tok(8'h06, 1'b1);
    push_tok(8'h0A, 1'b1);
    wait_idle();

    // Limit 4 with garbage upper bits; only ids 0 and 15 break
    write_reg(REG_BATCH_LIMIT, 16'hFFC4);
    write_reg(REG_PUNCT_MASK, 16'h8001);
    // cut after a break mid-buffer; ids 16 and up never break; ring at the limit
    // on the last token cuts first, then flushes
    push_tok(8'h03, 1'b0);
    push_tok(8'h00, 1'b0);
    push_tok(8'h12, 1'b0);
    push_tok(8'h10, 1'b0);
    push_tok(8'h20, 1'b0);
    push_tok(8'h0F, 1'b0);
    push_tok(8'h11, 1'b1);
    // no break at all: cut at the limit
    push_tok(8'h40, 1'b0);
    push_tok(8'h41, 1'b0);
    push_tok(8'h42, 1'b0);
    push_tok(8'h43, 1'b0);
    push_tok(8'h44, 1'b1);
    // three tokens left in the ring, then the limit drops to one
    push_tok(8'h80, 1'b0);
    push_tok(8'h81, 1'b0);
    push_tok(8'h82, 1'b0);
    wait_idle();
    write_reg(REG_BATCH_LIMIT, 16'h0001);
    push_tok(8'h83, 1'b1);
    wait_idle();

    // Limit field of zero acts as one
    write_reg(REG_BATCH_LIMIT, 16'h0040);
    push_tok(8'h05, 1'b0);
    push_tok(8'h07, 1'b1);
    wait_idle();

    // Limit above the ring depth, every low id breaks; writes to unused
    // indexes must change nothing
    write_reg(REG_BATCH_LIMIT, 16'h003F);
    write_reg(REG_PUNCT_MASK, 16'hFFFF);
    write_reg(REG_SPARE_2, 16'h0003);
    write_reg(REG_SPARE_3, 16'h1234);

    // Random part: three idling modes, two settings each
    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          src_idle_pct = 23;
          snk_idle_pct = 52;
        end
        1: begin
          src_idle_pct = 52;
          snk_idle_pct = 23;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      for (seg = 0; seg < 2; seg++) begin
        if (mode == 2 && seg == 0) begin
          // small limit so the ring fills quickly behind the hold-off
          write_reg(REG_BATCH_LIMIT, 16'h0006);
          write_reg(REG_PUNCT_MASK, MASK_W'($urandom_range(65535)));
          random_segment(18, 1'b0);
          hold_off_go = 1'b1;
        end else begin
          random_config();
          random_segment(18, seg == 0 && mode != 2);
        end
        wait_idle();
      end
    end

    while (batch_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d tokens in %0d sequences; checked %0d tokens in %0d batches.",
             tokens_in, seqs_in, tokens_out, batches_out);
    $display("%0d register writes (limit 0, 1, over depth, unused indexes); %0d-cycle hold-off.",
             reg_writes, HOLD_OFF_LEN);
    if (err_cnt == 0 && batch_q.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
